// ----- hdl/signed_floor_divider_unit_macros.svh -----
// assertion macros for the signed floor divider
`ifndef SIGNED_FLOOR_DIVIDER_UNIT_MACROS_SVH
`define SIGNED_FLOOR_DIVIDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk_i and disabled during reset
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT_NOW(label, ante, cons, msg)
`define SFD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/sfd_pkg.sv -----
// package: shared constants and types of the signed floor divider
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned STATUS_BITS   = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  // per-word side information carried along the pipeline
  typedef struct packed {
    logic neg;   // exactly one operand negative
    logic zero;  // divisor is zero
  } sfd_flags_t;

endpackage

// ----- hdl/sfd_step.sv -----
// one restoring division step: shifts in one dividend bit, yields one quotient bit
`timescale 1ns / 1ps

module sfd_step import sfd_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] dvd_i,
  input  logic [WORD_BITS-1:0] dsr_i,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] dvd_o
);

  logic [WORD_BITS:0] trial;
  logic [WORD_BITS:0] diff;
  logic               qbit;

  always_comb begin
    trial = {rem_i, dvd_i[WORD_BITS-1]};
    diff  = trial - {1'b0, dsr_i};
    qbit  = ~diff[WORD_BITS];
    rem_o = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    dvd_o = {dvd_i[WORD_BITS-2:0], qbit};
  end

endmodule

// ----- hdl/signed_floor_divider_unit.sv -----
// top level: pipelined signed floor divider
//
//   channel   dir   handshake                    payload
//   s_axis    in    s_axis_tvalid/s_axis_tready  tdata: dividend, divisor
//   m_axis    out   m_axis_tvalid/m_axis_tready  tdata: quotient; tuser: status
//
// one word per cycle sustained while m_axis_tready stays high; stages in order
// (sign strip, one restoring step per stage for WORD_BITS stages, fixup/output)
// reset clears only the valid bits of every stage
// each stage holds while the stage after it is full and stalled; bubbles close up,
// so words are still taken while a result waits at the output
`timescale 1ns / 1ps

`include "signed_floor_divider_unit_macros.svh"

module signed_floor_divider_unit import sfd_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // dividend, divisor, zero fill
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]           s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // quotient, zero fill
  output logic [((WORD_BITS+7)/8)*8-1:0]             m_axis_tdata,
  // status
  output logic [STATUS_BITS-1:0]                     m_axis_tuser
);

  localparam int unsigned OutDataBits = ((WORD_BITS+7)/8)*8;
  localparam logic [WORD_BITS-1:0] One    = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] MaxPos = {1'b0, {(WORD_BITS-1){1'b1}}};

  // stage 0 is the sign strip, stages 1..WORD_BITS the division steps
  logic [WORD_BITS:0]   vld_q;
  logic [WORD_BITS-1:0] rem_q  [0:WORD_BITS];
  logic [WORD_BITS-1:0] dvd_q  [0:WORD_BITS];
  logic [WORD_BITS-1:0] dsr_q  [0:WORD_BITS];
  sfd_flags_t           flg_q  [0:WORD_BITS];
  logic [WORD_BITS-1:0] rem_nx [1:WORD_BITS];
  logic [WORD_BITS-1:0] dvd_nx [1:WORD_BITS];

  logic [WORD_BITS+1:0] en;

  logic                 out_vld_q;
  logic [WORD_BITS-1:0] quo_q, quo_d;
  status_e              sts_q, sts_d;

  // sign strip
  logic [WORD_BITS-1:0] op_a, op_b, mag_a, mag_b;
  sfd_flags_t           flg_in;

  always_comb begin
    op_a        = s_axis_tdata[WORD_BITS-1:0];
    op_b        = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
    mag_a       = op_a[WORD_BITS-1] ? (~op_a + One) : op_a;
    mag_b       = op_b[WORD_BITS-1] ? (~op_b + One) : op_b;
    flg_in.neg  = op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
    flg_in.zero = ~(|op_b);
  end

  // a stage may load when it is empty or its word moves on
  always_comb begin
    en[WORD_BITS+1] = ~out_vld_q | m_axis_tready;
    for (int k = WORD_BITS; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en[0]) begin
      vld_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0] <= '0;
      dvd_q[0] <= mag_a;
      dsr_q[0] <= mag_b;
      flg_q[0] <= flg_in;
    end
  end

  for (genvar k = 1; k <= WORD_BITS; k++) begin : g_step
    sfd_step #(
      .WORD_BITS(WORD_BITS)
    ) u_step (
      .rem_i(rem_q[k-1]),
      .dvd_i(dvd_q[k-1]),
      .dsr_i(dsr_q[k-1]),
      .rem_o(rem_nx[k]),
      .dvd_o(dvd_nx[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= rem_nx[k];
        dvd_q[k] <= dvd_nx[k];
        dsr_q[k] <= dsr_q[k-1];
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  // fixup: -(q+1) is ~q, so a floor correction costs no extra adder
  always_comb begin
    quo_d = dvd_q[WORD_BITS];
    sts_d = STATUS_OK;
    if (flg_q[WORD_BITS].zero) begin
      quo_d = '0;
      sts_d = STATUS_DIV_ZERO;
    end else if (flg_q[WORD_BITS].neg) begin
      quo_d = (|rem_q[WORD_BITS]) ? ~dvd_q[WORD_BITS] : (~dvd_q[WORD_BITS] + One);
    end else if (dvd_q[WORD_BITS][WORD_BITS-1]) begin
      // only most negative over minus one lands here
      quo_d = MaxPos;
      sts_d = STATUS_OVERFLOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en[WORD_BITS+1]) begin
      out_vld_q <= vld_q[WORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[WORD_BITS+1]) begin
      quo_q <= quo_d;
      sts_q <= sts_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataBits'(quo_q);
  assign m_axis_tuser  = sts_q;

  `SFD_ASSERT_NOW(a_zero_gives_zero, out_vld_q && sts_q == STATUS_DIV_ZERO, quo_q == '0, "zero divisor must give zero quotient")
  `SFD_ASSERT_NOW(a_ovf_saturates, out_vld_q && sts_q == STATUS_OVERFLOW, quo_q == MaxPos, "overflow must saturate to max positive")
  `SFD_ASSERT_NOW(a_rem_below_dsr, vld_q[WORD_BITS] && !flg_q[WORD_BITS].zero, rem_q[WORD_BITS] < dsr_q[WORD_BITS], "final remainder not below divisor")
  `SFD_ASSERT_NEXT(a_last_step_holds, vld_q[WORD_BITS] && !en[WORD_BITS+1], vld_q[WORD_BITS] && $stable(dvd_q[WORD_BITS]), "stalled last step lost its word")

endmodule
